FILE: sv/pwmt_pkg.sv
// shared types and codes for the pwm timer
`timescale 1ns / 1ps

package pwmt_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int DATA_W          = 16;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	localparam logic [3:0] REG_CTRL     = 4'd0;
	localparam logic [3:0] REG_IRQ_EN   = 4'd1;
	localparam logic [3:0] REG_STATUS   = 4'd2;
	localparam logic [3:0] REG_EVENT    = 4'd3;
	localparam logic [3:0] REG_COUNT    = 4'd4;
	localparam logic [3:0] REG_PRESCALE = 4'd5;
	localparam logic [3:0] REG_RELOAD   = 4'd6;
	localparam logic [3:0] REG_COMPARE  = 4'd7;
	localparam logic [3:0] REG_CH_MODE  = 4'd8;
	localparam logic [3:0] REG_OUT_EN   = 4'd9;

	localparam logic [2:0] MODE_PWM1 = 3'd6;

	typedef struct packed {
		logic [1:0]        action;
		logic [3:0]        reg_sel;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              pwm_out;
		logic              irq_line;
		logic              update_event;
	} result_t;

endpackage

FILE: sv/pwmt_timer.sv
// timer register file, prescaler, counter and pwm compare
`timescale 1ns / 1ps

module pwmt_timer #(
	parameter int COUNT_WIDTH = pwmt_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  pwmt_pkg::item_t   item,
	output pwmt_pkg::result_t res
);

	localparam int CW = COUNT_WIDTH;
	localparam int DW = pwmt_pkg::DATA_W;

	logic [CW-1:0] psc_cnt_q, cnt_q, psc_buf_q, psc_act_q, arr_q, ccr_buf_q, ccr_act_q;
	logic [1:0]    ctrl_q;
	logic          uie_q, uif_q;
	logic [3:0]    ccmr_q;
	logic [1:0]    oe_q;

	logic [CW-1:0] psc_cnt_n, cnt_n, psc_buf_n, psc_act_n, arr_n, ccr_buf_n, ccr_act_n;
	logic [1:0]    ctrl_n;
	logic          uie_n, uif_n;
	logic [3:0]    ccmr_n;
	logic [1:0]    oe_n;

	logic          do_upd;
	logic [DW-1:0] rd;
	logic [CW+DW-1:0] wd_ext;
	logic [CW-1:0] wd;
	logic [CW+DW-1:0] cnt_ext, psc_ext, arr_ext, ccr_ext;

	// write data fitted to the counter width
	assign wd_ext  = {{CW{1'b0}}, item.write_data};
	assign wd      = wd_ext[CW-1:0];
	assign cnt_ext = {{DW{1'b0}}, cnt_q};
	assign psc_ext = {{DW{1'b0}}, psc_buf_q};
	assign arr_ext = {{DW{1'b0}}, arr_q};
	assign ccr_ext = {{DW{1'b0}}, ccr_buf_q};

	always_comb begin
		psc_cnt_n = psc_cnt_q;
		cnt_n     = cnt_q;
		psc_buf_n = psc_buf_q;
		psc_act_n = psc_act_q;
		arr_n     = arr_q;
		ccr_buf_n = ccr_buf_q;
		ccr_act_n = ccr_act_q;
		ctrl_n    = ctrl_q;
		uie_n     = uie_q;
		uif_n     = uif_q;
		ccmr_n    = ccmr_q;
		oe_n      = oe_q;
		do_upd    = 1'b0;
		rd        = '0;
		if (go) begin
			unique case (item.action)
				pwmt_pkg::ACT_TICK: begin
					if (ctrl_q[0]) begin
						if (psc_cnt_q < psc_act_q) begin
							psc_cnt_n = psc_cnt_q + CW'(1);
						end else begin
							psc_cnt_n = '0;
							if (cnt_q < arr_q) begin
								cnt_n = cnt_q + CW'(1);
							end else begin
								cnt_n  = '0;
								do_upd = 1'b1;
							end
						end
					end
				end
				pwmt_pkg::ACT_WRITE: begin
					unique case (item.reg_sel)
						pwmt_pkg::REG_CTRL:     ctrl_n = item.write_data[1:0];
						pwmt_pkg::REG_IRQ_EN:   uie_n = item.write_data[0];
						pwmt_pkg::REG_STATUS:   uif_n = uif_q & item.write_data[0];
						pwmt_pkg::REG_EVENT: begin
							if (item.write_data[0]) begin
								psc_cnt_n = '0;
								cnt_n     = '0;
								do_upd    = 1'b1;
							end
						end
						pwmt_pkg::REG_COUNT:    cnt_n = wd;
						pwmt_pkg::REG_PRESCALE: psc_buf_n = wd;
						pwmt_pkg::REG_RELOAD:   arr_n = wd;
						pwmt_pkg::REG_COMPARE: begin
							ccr_buf_n = wd;
							if (!ccmr_q[3]) begin
								ccr_act_n = wd;
							end
						end
						pwmt_pkg::REG_CH_MODE:  ccmr_n = item.write_data[3:0];
						pwmt_pkg::REG_OUT_EN:   oe_n = item.write_data[1:0];
						default: ;
					endcase
				end
				pwmt_pkg::ACT_READ: begin
					unique case (item.reg_sel)
						pwmt_pkg::REG_CTRL:     rd = {{(DW-2){1'b0}}, ctrl_q};
						pwmt_pkg::REG_IRQ_EN:   rd = {{(DW-1){1'b0}}, uie_q};
						pwmt_pkg::REG_STATUS:   rd = {{(DW-1){1'b0}}, uif_q};
						pwmt_pkg::REG_COUNT:    rd = cnt_ext[DW-1:0];
						pwmt_pkg::REG_PRESCALE: rd = psc_ext[DW-1:0];
						pwmt_pkg::REG_RELOAD:   rd = arr_ext[DW-1:0];
						pwmt_pkg::REG_COMPARE:  rd = ccr_ext[DW-1:0];
						pwmt_pkg::REG_CH_MODE:  rd = {{(DW-4){1'b0}}, ccmr_q};
						pwmt_pkg::REG_OUT_EN:   rd = {{(DW-2){1'b0}}, oe_q};
						default:                rd = '0;
					endcase
				end
				default: ;
			endcase
			// overflow or forced update: load buffers, set flag, one-pulse stop
			if (do_upd) begin
				uif_n     = 1'b1;
				psc_act_n = psc_buf_q;
				ccr_act_n = ccr_buf_q;
				if (ctrl_q[1]) begin
					ctrl_n[0] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_cnt_q <= '0;
			cnt_q     <= '0;
			psc_buf_q <= '0;
			psc_act_q <= '0;
			arr_q     <= '1;
			ccr_buf_q <= '0;
			ccr_act_q <= '0;
			ctrl_q    <= '0;
			uie_q     <= 1'b0;
			uif_q     <= 1'b0;
			ccmr_q    <= '0;
			oe_q      <= '0;
		end else begin
			psc_cnt_q <= psc_cnt_n;
			cnt_q     <= cnt_n;
			psc_buf_q <= psc_buf_n;
			psc_act_q <= psc_act_n;
			arr_q     <= arr_n;
			ccr_buf_q <= ccr_buf_n;
			ccr_act_q <= ccr_act_n;
			ctrl_q    <= ctrl_n;
			uie_q     <= uie_n;
			uif_q     <= uif_n;
			ccmr_q    <= ccmr_n;
			oe_q      <= oe_n;
		end
	end

	// pwm_out and irq_line reflect the state after this word; read_data is the value before it
	assign res.read_data    = rd;
	assign res.pwm_out      = (ccmr_n[2:0] == pwmt_pkg::MODE_PWM1) && (oe_n == 2'b11)
		&& (cnt_n < ccr_act_n);
	assign res.irq_line     = uif_n & uie_n;
	assign res.update_event = do_upd;

endmodule

FILE: sv/pwm_timer_with_one_pulse_core.sv
// top level: input register, timer core and result register
`timescale 1ns / 1ps

// Up-counting timer with buffered prescaler, auto-reload, one-pulse mode and one
// PWM mode 1 channel, driven by a stream of words: a count tick, a register write
// or a register read. One word is accepted every clock while in_stall is low; its
// result word passes from the input register to the result register and can be
// taken when the output is not stalled. The timer state is updated from the
// input register as each word moves on, so consecutive words see each other's
// effects with no gap. pwm_out and irq_line show the state after the word;
// read_data is the register value before it.
module pwm_timer_with_one_pulse_core #(
	parameter int COUNT_WIDTH = pwmt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [3:0]                  reg_sel,
	input  logic [pwmt_pkg::DATA_W-1:0] write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pwmt_pkg::DATA_W-1:0] read_data,
	output logic                        pwm_out,
	output logic                        irq_line,
	output logic                        update_event
);

	logic              vld_s1;
	pwmt_pkg::item_t   item_s1;
	logic              out_vld_q;
	pwmt_pkg::result_t res_q;
	pwmt_pkg::result_t res_n;
	logic              take;
	logic              accept;

	// a word in stage one moves on when the result register is free or draining
	assign take     = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && out_vld_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action     <= action;
			item_s1.reg_sel    <= reg_sel;
			item_s1.write_data <= write_data;
		end
	end

	pwmt_timer #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_timer (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (take),
		.item  (item_s1),
		.res   (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_n;
		end
	end

	assign out_valid    = out_vld_q;
	assign read_data    = res_q.read_data;
	assign pwm_out      = res_q.pwm_out;
	assign irq_line     = res_q.irq_line;
	assign update_event = res_q.update_event;

endmodule
